// ===== rtl/core/cma_pkg.sv =====
// Shared types and constants for the cone Monte Carlo accumulator.
package cma_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COUNT_BITS  = 32;
  localparam int COORD_W     = 17;
  localparam int HEIGHT_W    = 24;
  localparam int VALUE_W     = 24;
  localparam int SUM_W       = 56;
  localparam int DEV_W       = 54;
  localparam int SQ_W        = 34;
  localparam int D2_W        = 36;
  localparam int ROOT_W      = 18;
  localparam int REM_W       = 22;
  localparam int HD_W        = HEIGHT_W + ROOT_W;
  localparam int E2_W        = 2 * VALUE_W;
  localparam int TERM_W      = E2_W - FRAC_BITS;
  localparam int DIV_W       = 56;
  localparam int DEN_W       = COUNT_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int SQ_CNT_W    = $clog2(ROOT_W);
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 168;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [COORD_W-1:0]    CX_RESET = 17'd32768;
  localparam logic [COORD_W-1:0]    CY_RESET = 17'd32768;
  localparam logic [COORD_W-1:0]    R_RESET  = 17'd26214;
  localparam logic [HEIGHT_W-1:0]   H_RESET  = 24'd524288;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [DEV_W-1:0]      DEV_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X, REG_CENTER_Y, REG_CONE_RADIUS, REG_CONE_HEIGHT
  } cfg_reg_t;

  typedef enum logic [1:0] {DIV_VALUE, DIV_MEAN, DIV_DEV} div_sel_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_FIRST, ACC_HOLD, ACC_NORMAL} acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQUARE, ST_TEST, ST_SQRT, ST_HMUL, ST_VSTART, ST_VDIV, ST_VALUE,
    ST_MSTART, ST_MDIV, ST_ERR, ST_ESTART, ST_EDIV, ST_ACC, ST_OUT
  } state_t;

  typedef struct packed {
    logic     take_in;
    logic     do_square;
    logic     do_test;
    logic     sqrt_step;
    logic     do_hmul;
    logic     div_start;
    div_sel_t div_sel;
    logic     do_value;
    logic     do_err;
    acc_op_t  acc_op;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_circle;
    logic dist_zero;
    logic sqrt_done;
    logic div_done;
    logic new_run;
    logic saturated;
  } dp_stat_t;

endpackage

// ===== rtl/core/cone_monte_carlo_accumulator_unit.sv =====
// Top level of the cone Monte Carlo accumulator.
//
// One request on the slave stream carries a sample point (x, y) in unsigned
// Q1.16 and a first_sample flag in s_tuser; the block returns one result on
// the master stream: the cone value, the sample count, the running sum and
// the running sum of weighted squared deviations, with an overflow flag.
// The cone geometry is set through the configuration channel, which takes a
// write every cycle; write it only while no request is in flight.
// One request is processed at a time. A point outside the cone base starting
// a run skips the square root and the divider. The longest path runs an
// 18-step square root, then up to three passes of the shared bit-serial
// divider (height times distance over radius, sum over count, squared error
// over count plus one). The divider sets the throughput.
// The result sits in an output register, so the next request is taken while
// it waits; a request finishing while the receiver stalls holds until the
// register frees. Reset restores the default cone and clears count, sum and
// deviation sum; the next sample then starts a new run.
module cone_monte_carlo_accumulator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // x_coord [16:0], y_coord [33:17], zero fill
  input  logic [cma_pkg::IN_TDATA_W-1:0]  s_tdata,
  // first_sample
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // sample_value [23:0], sample_count [55:24], value_sum [111:56],
  // deviation_sum [165:112], overflow [166], zero fill
  output logic [cma_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import cma_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cma_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/core/cma_div.sv =====
// Restoring divider, one quotient bit per cycle.
module cma_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cma_pkg::DIV_W-1:0] num,
  input  logic [cma_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [cma_pkg::DIV_W-1:0] quo
);
  import cma_pkg::*;

  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W:0]       shifted;
  logic                 fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[DEN_W-1:0];
      end
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/cma_ctrl.sv =====
// Sequencer that steps one sample through the datapath.
module cma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  cma_pkg::dp_stat_t stat,
  output cma_pkg::dp_cmd_t  cmd
);
  import cma_pkg::*;

  state_t state, state_next;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_VALUE;
    cmd.acc_op  = ACC_NONE;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.take_in = 1'b1;
          state_next  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.do_square = 1'b1;
        state_next    = ST_TEST;
      end
      ST_TEST: begin
        cmd.do_test = 1'b1;
        state_next  = ST_SQRT;
      end
      ST_SQRT: begin
        // The in-circle flag is settled here; outside points skip the root.
        if (!stat.in_circle) begin
          state_next = ST_VALUE;
        end else begin
          cmd.sqrt_step = 1'b1;
          if (stat.sqrt_done) begin
            state_next = ST_HMUL;
          end
        end
      end
      ST_HMUL: begin
        if (stat.dist_zero) begin
          state_next = ST_VALUE;
        end else begin
          cmd.do_hmul = 1'b1;
          state_next  = ST_VSTART;
        end
      end
      ST_VSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VALUE;
        state_next    = ST_VDIV;
      end
      ST_VDIV: begin
        if (stat.div_done) begin
          state_next = ST_VALUE;
        end
      end
      ST_VALUE: begin
        cmd.do_value = 1'b1;
        if (stat.new_run || stat.saturated) begin
          state_next = ST_ACC;
        end else begin
          state_next = ST_MSTART;
        end
      end
      ST_MSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_next    = ST_MDIV;
      end
      ST_MDIV: begin
        if (stat.div_done) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.do_err = 1'b1;
        state_next = ST_ESTART;
      end
      ST_ESTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DEV;
        state_next    = ST_EDIV;
      end
      ST_EDIV: begin
        if (stat.div_done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        if (stat.new_run) begin
          cmd.acc_op = ACC_FIRST;
        end else if (stat.saturated) begin
          cmd.acc_op = ACC_HOLD;
        end else begin
          cmd.acc_op = ACC_NORMAL;
        end
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cma_dp.sv =====
// Datapath: cone evaluation, shared divider and running accumulators.
module cma_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [cma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [cma_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  output logic [cma_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  cma_pkg::dp_cmd_t                cmd,
  output cma_pkg::dp_stat_t               stat
);
  import cma_pkg::*;

  logic [COORD_W-1:0]    cx, cy, rad;
  logic [HEIGHT_W-1:0]   hgt;
  logic [COORD_W-1:0]    xin, yin;
  logic                  first;
  logic [SQ_W-1:0]       dx2, dy2, r2;
  logic                  in_circle;
  logic [D2_W-1:0]       sq_val;
  logic [ROOT_W-1:0]     sq_root;
  logic [REM_W-1:0]      sq_rem;
  logic [SQ_CNT_W-1:0]   sq_cnt;
  logic [HD_W-1:0]       hd;
  logic [VALUE_W-1:0]    value;
  logic [E2_W-1:0]       e2;
  logic [COUNT_BITS-1:0] count;
  logic [SUM_W-1:0]      sum;
  logic [DEV_W-1:0]      sqdev;
  logic                  ovf;
  logic [OUT_TDATA_W-1:0] out_data;

  logic [COORD_W-1:0]    dx, dy;
  logic [SQ_W:0]         d2_sum;
  logic [REM_W-1:0]      rem_sh, trial;
  logic [VALUE_W-1:0]    mean, err;
  logic [TERM_W-1:0]     term;
  logic [DEV_W:0]        dev_sum;
  logic [DIV_W-1:0]      div_num, quo;
  logic [DEN_W-1:0]      div_den;
  logic                  div_busy, div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= CX_RESET;
      cy  <= CY_RESET;
      rad <= R_RESET;
      hgt <= H_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:    cx  <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:    cy  <= cfg_data[COORD_W-1:0];
        REG_CONE_RADIUS: rad <= cfg_data[COORD_W-1:0];
        REG_CONE_HEIGHT: hgt <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign dx     = (xin >= cx) ? xin - cx : cx - xin;
  assign dy     = (yin >= cy) ? yin - cy : cy - yin;
  assign d2_sum = {1'b0, dx2} + {1'b0, dy2};

  // One root bit per step: bring down two radicand bits and try 4*root+1.
  assign rem_sh = {sq_rem[REM_W-3:0], sq_val[D2_W-1:D2_W-2]};
  assign trial  = {{(REM_W - ROOT_W - 2){1'b0}}, sq_root, 2'b01};

  // The mean never exceeds the largest sample, so it fits the value width.
  assign mean = quo[VALUE_W-1:0];
  assign err  = (value >= mean) ? value - mean : mean - value;
  assign term = TERM_W'((e2 - quo[E2_W-1:0]) >> FRAC_BITS);
  assign dev_sum = {1'b0, sqdev} + (DEV_W + 1)'(term);

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      xin   <= s_tdata[COORD_W-1:0];
      yin   <= s_tdata[2*COORD_W-1:COORD_W];
      first <= s_tuser;
    end
    if (cmd.do_square) begin
      dx2 <= dx * dx;
      dy2 <= dy * dy;
      r2  <= rad * rad;
    end
    if (cmd.do_test) begin
      in_circle <= d2_sum <= {1'b0, r2};
      sq_val    <= D2_W'(d2_sum);
      sq_root   <= '0;
      sq_rem    <= '0;
      sq_cnt    <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_val <= {sq_val[D2_W-3:0], 2'b00};
      sq_cnt <= sq_cnt + 1'b1;
      if (rem_sh >= trial) begin
        sq_rem  <= rem_sh - trial;
        sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= rem_sh;
        sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.do_hmul) begin
      hd <= hgt * sq_root;
    end
    if (cmd.do_value) begin
      if (!in_circle) begin
        value <= '0;
      end else if (sq_root == '0) begin
        value <= hgt;
      end else begin
        value <= hgt - quo[VALUE_W-1:0];
      end
    end
    if (cmd.do_err) begin
      e2 <= err * err;
    end
    if (cmd.out_load) begin
      out_data <= {1'b0, ovf, sqdev, sum, count, value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      sqdev <= '0;
      ovf   <= 1'b0;
    end else begin
      case (cmd.acc_op)
        ACC_FIRST: begin
          count <= COUNT_BITS'(1);
          sum   <= SUM_W'(value);
          sqdev <= '0;
          ovf   <= 1'b0;
        end
        ACC_HOLD: begin
          ovf <= 1'b1;
        end
        ACC_NORMAL: begin
          count <= count + 1'b1;
          sum   <= sum + SUM_W'(value);
          sqdev <= dev_sum[DEV_W] ? DEV_MAX : dev_sum[DEV_W-1:0];
          ovf   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_VALUE: begin
        div_num = DIV_W'(hd);
        div_den = DEN_W'(rad);
      end
      DIV_MEAN: begin
        div_num = sum;
        div_den = {1'b0, count};
      end
      DIV_DEV: begin
        div_num = DIV_W'(e2);
        div_den = {1'b0, count} + 1'b1;
      end
      default: begin
        div_num = '0;
        div_den = DEN_W'(1);
      end
    endcase
  end

  cma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  assign stat.in_circle = in_circle;
  assign stat.dist_zero = sq_root == '0;
  assign stat.sqrt_done = sq_cnt == SQ_CNT_W'(ROOT_W - 1);
  assign stat.div_done  = div_done;
  assign stat.new_run   = first || (count == '0);
  assign stat.saturated = count == COUNT_MAX;
  assign m_tdata        = out_data;

`ifndef NO_ASSERTIONS
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_first_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_op == ACC_FIRST |=> count == COUNT_BITS'(1) && sqdev == '0)
    else $error("new run did not reset the accumulators");
  a_hold_keeps: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_op == ACC_HOLD |=> $stable(count) && $stable(sum) && $stable(sqdev))
    else $error("saturated sample changed the accumulators");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_op == ACC_NORMAL |=> count == $past(count) + 1'b1)
    else $error("count did not advance by one");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the cone Monte Carlo accumulator: directed table, random runs, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import cma_pkg::*;

  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic        first;
  } point_t;

  typedef struct packed {
    logic        ovf;
    logic [53:0] dev;
    logic [55:0] sum;
    logic [31:0] cnt;
    logic [23:0] val;
  } acc_result_t;

  // One row of the directed table; has_val marks rows whose value is typed in.
  typedef struct {
    logic [16:0] x;
    logic [16:0] y;
    logic        first;
    logic        has_val;
    logic [23:0] val;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  always #5 clk = ~clk;

  cone_monte_carlo_accumulator_unit u_top (.*);

  // Predictor state.
  logic [16:0] cx, cy, rad;
  logic [23:0] hgt;
  logic [31:0] cnt_q;
  logic [55:0] sum_q;
  logic [53:0] dev_q;

  acc_result_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  logic stall_mode = 1'b0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [23:0] cone_at(input logic [16:0] x, input logic [16:0] y);
    logic [63:0] dx, dy, d2, r2, root_d;
    dx = (x >= cx) ? x - cx : cx - x;
    dy = (y >= cy) ? y - cy : cy - y;
    d2 = dx * dx + dy * dy;
    r2 = 64'(rad) * rad;
    if (d2 > r2) return '0;
    root_d = int_sqrt(d2);
    if (root_d == 0 || rad == 0) return hgt;
    return hgt - 24'((64'(hgt) * root_d) / rad);
  endfunction

  function automatic acc_result_t accumulate(input point_t p);
    acc_result_t r;
    logic [63:0] j, mean, e, e2, term, room;
    r.val = cone_at(p.x, p.y);
    r.ovf = 1'b0;
    if (p.first || cnt_q == 0) begin
      cnt_q = 1;
      sum_q = 56'(r.val);
      dev_q = '0;
    end else if (cnt_q == COUNT_MAX) begin
      r.ovf = 1'b1;
    end else begin
      j = cnt_q;
      mean = 64'(sum_q) / j;
      e = (r.val >= mean) ? r.val - mean : mean - r.val;
      e2 = e * e;
      term = (e2 - e2 / (j + 1)) >> FRAC_BITS;
      room = 64'(DEV_MAX) - dev_q;
      dev_q = (term > room) ? DEV_MAX : dev_q + 54'(term);
      sum_q = sum_q + r.val;
      cnt_q = cnt_q + 1;
    end
    r.cnt = cnt_q;
    r.sum = sum_q;
    r.dev = dev_q;
    return r;
  endfunction

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("cone_monte_carlo_accumulator_unit regression: fail");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        acc_result_t got, want;
        got = acc_result_t'(m_tdata[166:0]);
        if (pending_q.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got.val !== want.val) begin
            $error("sample_value exp %h got %h", want.val, got.val); errors++;
          end
          if (got.cnt !== want.cnt) begin
            $error("sample_count exp %h got %h", want.cnt, got.cnt); errors++;
          end
          if (got.sum !== want.sum) begin
            $error("value_sum exp %h got %h", want.sum, got.sum); errors++;
          end
          if (got.dev !== want.dev) begin
            $error("deviation_sum exp %h got %h", want.dev, got.dev); errors++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow exp %b got %b", want.ovf, got.ovf); errors++;
          end
        end
      end
    end
  end

  // Receiver: alternates between a free-running stretch and random stalls.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER_X:    cx = val[16:0];
      REG_CENTER_Y:    cy = val[16:0];
      REG_CONE_RADIUS: rad = val[16:0];
      default:         hgt = val;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // Sends one request; tvalid stays high until the caller drops it.
  task automatic send_point(input point_t p);
    acc_result_t r;
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, p.y, p.x};
    s_tuser <= p.first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = accumulate(p);
    pending_q.push_back(r);
  endtask

  task automatic send_check(input point_t p, input bit has_val, input logic [23:0] val);
    if (has_val && cone_at(p.x, p.y) !== val) begin
      $error("table value exp %h model %h", val, cone_at(p.x, p.y));
      errors++;
    end
    send_point(p);
  endtask

  task automatic random_burst(input int n, input int run_len);
    int burst;
    int gap;
    point_t p;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      p.x = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      p.y = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      p.first = ($urandom_range(0, run_len) == 0);
      burst--;
      send_point(p);
    end
  endtask

  row_t table_rows[] = '{
    '{17'd32768, 17'd32768, 1'b1, 1'b1, 24'd524288},
    '{17'd0, 17'd0, 1'b0, 1'b1, 24'd0},
    '{17'd65536, 17'd65536, 1'b0, 1'b1, 24'd0},
    '{17'd32768 + 17'd26214, 17'd32768, 1'b0, 1'b1, 24'd0},
    '{17'd40000, 17'd30000, 1'b0, 1'b0, 24'd0},
    '{17'h1FFFF, 17'h1FFFF, 1'b0, 1'b1, 24'd0},
    '{17'd32768, 17'd20000, 1'b1, 1'b0, 24'd0},
    '{17'd33000, 17'd33000, 1'b0, 1'b0, 24'd0},
    '{17'd0, 17'd65536, 1'b0, 1'b1, 24'd0},
    '{17'd32769, 17'd32768, 1'b0, 1'b0, 24'd0}
  };

  initial begin
    point_t p;
    cx = CX_RESET; cy = CY_RESET; rad = R_RESET; hgt = H_RESET;
    cnt_q = '0; sum_q = '0; dev_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset geometry; the first sample arrives with no run open.
    p = '{17'd32768, 17'd32768, 1'b0};
    send_check(p, 1'b1, 24'd524288);
    foreach (table_rows[i]) begin
      p = '{table_rows[i].x, table_rows[i].y, table_rows[i].first};
      send_check(p, table_rows[i].has_val, table_rows[i].val);
    end
    wait_drained();

    // Zero radius: only the exact centre gets the full height.
    write_reg(REG_CONE_RADIUS, 24'd0);
    write_reg(REG_CONE_HEIGHT, 24'hFFFFFF);
    send_check('{17'd32768, 17'd32768, 1'b1}, 1'b1, 24'hFFFFFF);
    send_check('{17'd32769, 17'd32768, 1'b0}, 1'b1, 24'd0);
    wait_drained();

    // Largest cone with extreme centres; the deviation sum grows fast.
    write_reg(REG_CENTER_X, 24'd0);
    write_reg(REG_CENTER_Y, 24'h1FFFF);
    write_reg(REG_CONE_RADIUS, 24'h1FFFF);
    send_check('{17'd0, 17'h1FFFF, 1'b1}, 1'b1, 24'hFFFFFF);
    send_check('{17'h1FFFF, 17'd0, 1'b0}, 1'b0, 24'd0);
    send_check('{17'd0, 17'd0, 1'b0}, 1'b0, 24'd0);
    random_burst(300, 40);
    wait_drained();

    // Zero height, then random geometries.
    write_reg(REG_CONE_HEIGHT, 24'd0);
    write_reg(REG_CENTER_X, 24'd65536);
    write_reg(REG_CENTER_Y, 24'd0);
    random_burst(50, 10);
    wait_drained();
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_CENTER_X, 24'($urandom_range(0, 65536)));
      write_reg(REG_CENTER_Y, 24'($urandom_range(0, 65536)));
      write_reg(REG_CONE_RADIUS, 24'($urandom_range(1, 65536)));
      write_reg(REG_CONE_HEIGHT, 24'($urandom));
      random_burst(200, 30);
      wait_drained();
    end

    if (errors == 0)
      $display("cone_monte_carlo_accumulator_unit regression: pass");
    else
      $display("cone_monte_carlo_accumulator_unit regression: fail");
    $finish;
  end
endmodule
